/* design/csa_pkg.sv */
// Shared types and constants for the CAN feedback snapshot assembler.
package csa_pkg;

  localparam int unsigned IdW      = 29;
  localparam int unsigned CfgIdW   = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned SeqW     = 16;
  localparam int unsigned WordW    = 40;
  localparam int unsigned VelW     = 34;
  localparam int unsigned PosW     = 32;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 240;
  localparam int unsigned OutUserW = 4;

  localparam logic [2:0] CFG_PROTOCOL_VERSION = 3'd0;
  localparam logic [2:0] CFG_BASE_FEEDBACK_ID = 3'd1;
  localparam logic [2:0] CFG_DIAGNOSTICS_ID   = 3'd2;
  localparam logic [2:0] CFG_OPTIONAL_ID_A    = 3'd3;
  localparam logic [2:0] CFG_OPTIONAL_ID_B    = 3'd4;

  localparam logic [2:0] SLOT_STATUS = 3'd0;
  localparam logic [2:0] SLOT_HEALTH = 3'd1;
  localparam logic [2:0] SLOT_VEL    = 3'd2;
  localparam logic [2:0] SLOT_LEFT   = 3'd3;
  localparam logic [2:0] SLOT_RIGHT  = 3'd4;
  localparam logic [2:0] SLOT_DIAG   = 3'd5;

  localparam logic [5:0] SLOTS_ALL = 6'h3F;
  localparam logic [3:0] FRAME_LEN = 4'd8;
  localparam logic [SeqW-1:0] SEQ_WINDOW = 16'h7FFF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXTENDED  = 3'd1,
    ST_REMOTE    = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_BAD_LEN   = 3'd4,
    ST_BAD_VER   = 3'd5,
    ST_BAD_FLAGS = 3'd6,
    ST_MISMATCH  = 3'd7
  } status_e;

  // Outcome of the per-frame checks, handed to the snapshot stage
  typedef struct packed {
    logic            rejected;
    status_e         status;
    logic            optional_id;
    logic [2:0]      slot;
    logic [SeqW-1:0] seq;
    logic [WordW-1:0] payload;  // payload bytes 3..7
    logic [3:0]      drive_flags;
  } dec_t;

endpackage

/* design/csa_frame_check.sv */
// Frame checks, slot selection and derived drive flags for one received word.
module csa_frame_check (
  input  logic [csa_pkg::IdW-1:0]    frame_id_i,
  input  logic                       is_extended_i,
  input  logic                       is_remote_i,
  input  logic [3:0]                 data_length_i,
  input  logic [63:0]                frame_data_i,
  input  logic [7:0]                 protocol_version_i,
  input  logic [csa_pkg::CfgIdW-1:0] base_feedback_id_i,
  input  logic [csa_pkg::CfgIdW-1:0] diagnostics_id_i,
  input  logic [csa_pkg::CfgIdW-1:0] optional_id_a_i,
  input  logic [csa_pkg::CfgIdW-1:0] optional_id_b_i,
  output csa_pkg::dec_t              dec_o
);

  logic [csa_pkg::CfgIdW:0] base_top;
  logic       main_id, diag_id, opt_id;
  logic [2:0] slot;
  logic [7:0] f3, st, act, age, err;
  logic       known, calib, fresh, drive;

  assign base_top = {1'b0, base_feedback_id_i} + 12'd4;
  assign main_id  = (frame_id_i >= {18'd0, base_feedback_id_i}) &&
                    (frame_id_i <= {17'd0, base_top});
  assign diag_id  = !main_id && (frame_id_i == {18'd0, diagnostics_id_i});
  assign opt_id   = (frame_id_i == {18'd0, optional_id_a_i}) ||
                    (frame_id_i == {18'd0, optional_id_b_i});
  assign slot     = main_id ? (frame_id_i[2:0] - base_feedback_id_i[2:0])
                            : csa_pkg::SLOT_DIAG;

  assign f3  = frame_data_i[31:24];
  assign st  = frame_data_i[39:32];
  assign act = frame_data_i[47:40];
  assign age = frame_data_i[55:48];
  assign err = frame_data_i[63:56];

  assign known = (st <= 8'd7) && (act <= 8'd3) && (err <= 8'd4);
  assign calib = f3[0] || (st == 8'd1) || (st == 8'd2) || (act == 8'd2);
  assign fresh = f3[2] && (age <= 8'd9);
  assign drive = known && !calib && fresh && (st == 8'd4) && (act == 8'd1) &&
                 f3[1] && f3[2] && ((f3 & 8'hF9) == 8'd0) && (err == 8'd0);

  always_comb begin
    dec_o             = '0;
    dec_o.status      = csa_pkg::ST_OK;
    dec_o.slot        = slot;
    dec_o.seq         = frame_data_i[23:8];
    dec_o.payload     = frame_data_i[63:24];
    dec_o.drive_flags = {drive, fresh, calib, known};
    if (is_extended_i) begin
      dec_o.rejected = 1'b1;
      dec_o.status   = csa_pkg::ST_EXTENDED;
    end else if (is_remote_i) begin
      dec_o.rejected = 1'b1;
      dec_o.status   = csa_pkg::ST_REMOTE;
    end else if (!main_id && !diag_id && !opt_id) begin
      dec_o.rejected = 1'b1;
      dec_o.status   = csa_pkg::ST_UNKNOWN;
    end else if (data_length_i != csa_pkg::FRAME_LEN) begin
      dec_o.rejected = 1'b1;
      dec_o.status   = csa_pkg::ST_BAD_LEN;
    end else if (frame_data_i[7:0] != protocol_version_i) begin
      dec_o.rejected = 1'b1;
      dec_o.status   = csa_pkg::ST_BAD_VER;
    end else if (!main_id && !diag_id) begin
      dec_o.optional_id = 1'b1;
    end else if (((slot == csa_pkg::SLOT_HEALTH) && f3[4]) ||
                 ((slot == csa_pkg::SLOT_VEL) && ((f3 & 8'hFC) != 8'd0)) ||
                 (((slot == csa_pkg::SLOT_LEFT) || (slot == csa_pkg::SLOT_RIGHT)) &&
                  ((f3 & 8'hFE) != 8'd0))) begin
      dec_o.rejected = 1'b1;
      dec_o.status   = csa_pkg::ST_BAD_FLAGS;
    end
  end

endmodule

/* design/csa_snapshot.sv */
// Pending snapshot state, sequence window and the result register.
module csa_snapshot (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  input  logic                           cmd_i,
  input  csa_pkg::dec_t                  dec_i,
  output logic                           advance_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [csa_pkg::OutUserW-1:0]   m_axis_tuser,
  output logic [csa_pkg::OutDataW-1:0]   m_axis_tdata
);

  logic                      pend_valid_q, pend_valid_d;
  logic [csa_pkg::SeqW-1:0]  pend_seq_q, pend_seq_d;
  logic [5:0]                slots_q, slots_d;
  logic [csa_pkg::WordW-1:0] h_status_q, h_status_d;
  logic [csa_pkg::WordW-1:0] h_health_q, h_health_d;
  logic [csa_pkg::VelW-1:0]  h_vel_q, h_vel_d;
  logic [32:0]               h_left_q, h_left_d;
  logic [32:0]               h_right_q, h_right_d;
  logic [csa_pkg::WordW-1:0] h_diag_q, h_diag_d;
  logic [3:0]                h_drive_q, h_drive_d;

  logic                        m_valid_q;
  logic [csa_pkg::OutUserW-1:0] m_user_q, m_user_d;
  logic [csa_pkg::OutDataW-1:0] m_data_q, m_data_d;

  logic [csa_pkg::SeqW-1:0] fwd;
  logic                     fresh_start;
  csa_pkg::status_e         status;
  logic                     snap_valid;

  assign advance_o = item_valid_i && (!m_valid_q || m_axis_tready);
  assign fwd       = dec_i.seq - pend_seq_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_seq_d   = pend_seq_q;
    slots_d      = slots_q;
    h_status_d   = h_status_q;
    h_health_d   = h_health_q;
    h_vel_d      = h_vel_q;
    h_left_d     = h_left_q;
    h_right_d    = h_right_q;
    h_diag_d     = h_diag_q;
    h_drive_d    = h_drive_q;
    status       = csa_pkg::ST_OK;
    snap_valid   = 1'b0;
    fresh_start  = !pend_valid_q || (fwd != '0);
    if (cmd_i) begin
      pend_valid_d = 1'b0;
      pend_seq_d   = '0;
      slots_d      = '0;
      h_status_d   = '0;
      h_health_d   = '0;
      h_vel_d      = '0;
      h_left_d     = '0;
      h_right_d    = '0;
      h_diag_d     = '0;
      h_drive_d    = '0;
    end else if (dec_i.rejected) begin
      status = dec_i.status;
    end else if (dec_i.optional_id) begin
      status = csa_pkg::ST_OK;
    end else if (pend_valid_q && (fwd == '0) && slots_q[dec_i.slot]) begin
      status = csa_pkg::ST_OK;
    end else if (pend_valid_q && (fwd > csa_pkg::SEQ_WINDOW)) begin
      status = csa_pkg::ST_MISMATCH;
    end else begin
      if (fresh_start) begin
        pend_valid_d = 1'b1;
        pend_seq_d   = dec_i.seq;
        slots_d      = '0;
        h_status_d   = '0;
        h_health_d   = '0;
        h_vel_d      = '0;
        h_left_d     = '0;
        h_right_d    = '0;
        h_diag_d     = '0;
        h_drive_d    = '0;
      end
      slots_d[dec_i.slot] = 1'b1;
      case (dec_i.slot)
        csa_pkg::SLOT_STATUS: h_status_d = dec_i.payload;
        csa_pkg::SLOT_HEALTH: h_health_d = dec_i.payload;
        csa_pkg::SLOT_VEL:    h_vel_d    = {dec_i.payload[1:0], dec_i.payload[39:8]};
        csa_pkg::SLOT_LEFT:   h_left_d   = {dec_i.payload[0], dec_i.payload[39:8]};
        csa_pkg::SLOT_RIGHT:  h_right_d  = {dec_i.payload[0], dec_i.payload[39:8]};
        default: begin
          h_diag_d  = dec_i.payload;
          h_drive_d = dec_i.drive_flags;
        end
      endcase
      snap_valid = (slots_d == csa_pkg::SLOTS_ALL);
    end
  end

  always_comb begin
    m_user_d = {snap_valid, status};
    m_data_d = '0;
    if (snap_valid) begin
      m_data_d = {h_drive_d, h_diag_d, h_right_d[32], h_left_d[32], h_right_d[31:0],
                  h_left_d[31:0], h_vel_d, h_health_d, h_status_d, pend_seq_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_seq_q   <= '0;
      slots_q      <= '0;
      h_status_q   <= '0;
      h_health_q   <= '0;
      h_vel_q      <= '0;
      h_left_q     <= '0;
      h_right_q    <= '0;
      h_diag_q     <= '0;
      h_drive_q    <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (advance_o) begin
        pend_valid_q <= pend_valid_d;
        pend_seq_q   <= pend_seq_d;
        slots_q      <= slots_d;
        h_status_q   <= h_status_d;
        h_health_q   <= h_health_d;
        h_vel_q      <= h_vel_d;
        h_left_q     <= h_left_d;
        h_right_q    <= h_right_d;
        h_diag_q     <= h_diag_d;
        h_drive_q    <= h_drive_d;
        m_valid_q    <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      m_user_q <= m_user_d;
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

  a_snap_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_user_q[3]) |-> (m_user_q[2:0] == csa_pkg::ST_OK))
    else $error("complete snapshot reported with error status");

  a_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_o && cmd_i) |=> (!pend_valid_q && (slots_q == '0)))
    else $error("discard left pending state");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_valid_q |-> (slots_q == '0))
    else $error("slots filled without a pending sequence");

  a_snap_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_user_q[3]) |-> (pend_valid_q && (m_data_q[15:0] == pend_seq_q)))
    else $error("snapshot word does not match pending sequence");

endmodule

/* design/can_feedback_snapshot_assembler_core.sv */
// Top level: config registers, input register, frame checks and snapshot stage.
// The result word passes through the input register, then the result register.
// Throughput: one word per cycle unless the output stalls; the pending state updates
// in the same cycle as the checks. Input ready drops only when both the input and
// result registers hold words and the output is stalled.
// Reset: no pending snapshot, held words zero, config registers at their default IDs.
module can_feedback_snapshot_assembler_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tuser: cmd
  input  logic                            s_axis_tuser,
  // tdata: frame_id[28:0], is_extended[29], is_remote[30], data_length[34:31],
  //        frame_data[98:35], zero pad
  input  logic [csa_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tuser: decode_status[2:0], snapshot_valid[3]
  output logic [csa_pkg::OutUserW-1:0]    m_axis_tuser,
  // tdata: snapshot_sequence[15:0], status_word[55:16], health_word[95:56],
  //        velocity_word[129:96], left_position[161:130], right_position[193:162],
  //        position_valid[195:194], diagnostics_word[235:196], drive_flags[239:236]
  output logic [csa_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [csa_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [csa_pkg::CfgIdW-1:0]      cfg_data_i
);

  logic [7:0]                 ver_q;
  logic [csa_pkg::CfgIdW-1:0] base_q, diag_q, opt_a_q, opt_b_q;

  logic                       in_valid_q;
  logic                       cmd_q;
  logic [98:0]                in_data_q;
  logic                       advance;
  csa_pkg::dec_t              dec;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q   <= 8'd1;
      base_q  <= 11'd256;
      diag_q  <= 11'd261;
      opt_a_q <= 11'd262;
      opt_b_q <= 11'd263;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        csa_pkg::CFG_PROTOCOL_VERSION: ver_q   <= cfg_data_i[7:0];
        csa_pkg::CFG_BASE_FEEDBACK_ID: base_q  <= cfg_data_i;
        csa_pkg::CFG_DIAGNOSTICS_ID:   diag_q  <= cfg_data_i;
        csa_pkg::CFG_OPTIONAL_ID_A:    opt_a_q <= cfg_data_i;
        csa_pkg::CFG_OPTIONAL_ID_B:    opt_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q     <= s_axis_tuser;
      in_data_q <= s_axis_tdata[98:0];
    end
  end

  csa_frame_check u_check (
    .frame_id_i         (in_data_q[28:0]),
    .is_extended_i      (in_data_q[29]),
    .is_remote_i        (in_data_q[30]),
    .data_length_i      (in_data_q[34:31]),
    .frame_data_i       (in_data_q[98:35]),
    .protocol_version_i (ver_q),
    .base_feedback_id_i (base_q),
    .diagnostics_id_i   (diag_q),
    .optional_id_a_i    (opt_a_q),
    .optional_id_b_i    (opt_b_q),
    .dec_o              (dec)
  );

  csa_snapshot u_snap (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (in_valid_q),
    .cmd_i         (cmd_q),
    .dec_i         (dec),
    .advance_o     (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* verif/tb.sv */
// Testbench for the CAN feedback snapshot assembler: random and directed frames, scoreboard.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxPrinted = 40;

  typedef struct packed {
    logic        cmd;
    logic [28:0] id;
    logic        ext;
    logic        rem;
    logic [3:0]  len;
    logic [63:0] data;
  } can_frame_t;

  typedef struct packed {
    csa_pkg::status_e status;
    logic        valid;
    logic [15:0] seq;
    logic [39:0] status_w;
    logic [39:0] health_w;
    logic [33:0] vel_w;
    logic [31:0] left;
    logic [31:0] right;
    logic [1:0]  pos_v;
    logic [39:0] diag_w;
    logic [3:0]  flags;
  } snapshot_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic                          s_axis_tuser = 1'b0;
  logic [csa_pkg::InDataW-1:0]   s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [csa_pkg::OutUserW-1:0]  m_axis_tuser;
  logic [csa_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [csa_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [csa_pkg::CfgIdW-1:0]    cfg_data_i = '0;

  // register copies, reset values
  logic [7:0]  proto_ver = 8'd1;
  logic [10:0] base_id = 11'd256;
  logic [10:0] diag_id = 11'd261;
  logic [10:0] opt_a = 11'd262;
  logic [10:0] opt_b = 11'd263;

  // pending snapshot
  logic        pend_valid = 1'b0;
  logic [15:0] pend_seq = '0;
  logic [5:0]  slots_got = '0;
  logic [39:0] held_status = '0;
  logic [39:0] held_health = '0;
  logic [33:0] held_vel = '0;
  logic [32:0] held_left = '0;
  logic [32:0] held_right = '0;
  logic [39:0] held_diag = '0;
  logic [3:0]  held_flags = '0;

  can_frame_t  frame_q[$];
  snapshot_t   snap_exp_q[$];
  can_frame_t  cur_frame;
  snapshot_t   want_snap;
  logic [15:0] gen_seq = '0;
  int unsigned idle_pct = 24;
  int unsigned stall_pct = 24;
  int unsigned fault_cnt = 0;
  int unsigned words_seen = 0;
  int unsigned cycle_cnt = 0;

  can_feedback_snapshot_assembler_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [3:0] drive_flags_of(input logic [63:0] d);
    logic [7:0] fl, st, act, age, err;
    logic known, calib, fresh, drive;
    {err, age, act, st, fl} = d[63:24];
    known = st <= 8'd7 && act <= 8'd3 && err <= 8'd4;
    calib = fl[0] || st == 8'd1 || st == 8'd2 || act == 8'd2;
    fresh = fl[2] && age <= 8'd9;
    drive = known && !calib && fresh && st == 8'd4 && act == 8'd1 && fl[1] && fl[2] &&
            (fl & 8'hF9) == 8'h00 && err == 8'd0;
    return {drive, fresh, calib, known};
  endfunction

  task automatic drop_pending();
    pend_valid  = 1'b0;
    pend_seq    = '0;
    slots_got   = '0;
    held_status = '0;
    held_health = '0;
    held_vel    = '0;
    held_left   = '0;
    held_right  = '0;
    held_diag   = '0;
    held_flags  = '0;
  endtask

  task automatic assemble_snapshot(input can_frame_t f);
    snapshot_t   r;
    logic        main_hit, diag_hit, fresh;
    logic [2:0]  slot;
    logic [7:0]  f3;
    logic [15:0] seq, fwd;
    int unsigned id_w, base_w;
    r = '0;
    r.status = csa_pkg::ST_OK;
    id_w = 32'(f.id);
    base_w = 32'(base_id);
    if (f.cmd) begin
      drop_pending();
    end else if (f.ext) begin
      r.status = csa_pkg::ST_EXTENDED;
    end else if (f.rem) begin
      r.status = csa_pkg::ST_REMOTE;
    end else begin
      main_hit = id_w >= base_w && id_w <= base_w + 4;
      diag_hit = !main_hit && f.id == 29'(diag_id);
      if (!main_hit && !diag_hit) begin
        if (f.id != 29'(opt_a) && f.id != 29'(opt_b)) r.status = csa_pkg::ST_UNKNOWN;
        else if (f.len != csa_pkg::FRAME_LEN) r.status = csa_pkg::ST_BAD_LEN;
        else if (f.data[7:0] != proto_ver) r.status = csa_pkg::ST_BAD_VER;
      end else if (f.len != csa_pkg::FRAME_LEN) begin
        r.status = csa_pkg::ST_BAD_LEN;
      end else if (f.data[7:0] != proto_ver) begin
        r.status = csa_pkg::ST_BAD_VER;
      end else begin
        slot = main_hit ? 3'(id_w - base_w) : csa_pkg::SLOT_DIAG;
        f3 = f.data[31:24];
        if ((slot == csa_pkg::SLOT_HEALTH && f3[4]) ||
            (slot == csa_pkg::SLOT_VEL && |f3[7:2]) ||
            ((slot == csa_pkg::SLOT_LEFT || slot == csa_pkg::SLOT_RIGHT) && |f3[7:1])) begin
          r.status = csa_pkg::ST_BAD_FLAGS;
        end else begin
          seq = f.data[23:8];
          fwd = seq - pend_seq;
          fresh = !pend_valid;
          if (pend_valid && fwd != 16'd0) begin
            if (fwd <= csa_pkg::SEQ_WINDOW) fresh = 1'b1;
            else r.status = csa_pkg::ST_MISMATCH;
          end
          // a slot already filled for this sequence is left alone
          if (r.status == csa_pkg::ST_OK &&
              !(pend_valid && fwd == 16'd0 && slots_got[slot])) begin
            if (fresh) begin
              drop_pending();
              pend_valid = 1'b1;
              pend_seq = seq;
            end
            slots_got[slot] = 1'b1;
            case (slot)
              csa_pkg::SLOT_STATUS: held_status = f.data[63:24];
              csa_pkg::SLOT_HEALTH: held_health = f.data[63:24];
              csa_pkg::SLOT_VEL:    held_vel = {f3[1:0], f.data[63:32]};
              csa_pkg::SLOT_LEFT:   held_left = {f3[0], f.data[63:32]};
              csa_pkg::SLOT_RIGHT:  held_right = {f3[0], f.data[63:32]};
              default: begin
                held_diag = f.data[63:24];
                held_flags = drive_flags_of(f.data);
              end
            endcase
            if (slots_got == csa_pkg::SLOTS_ALL) begin
              r.valid    = 1'b1;
              r.seq      = pend_seq;
              r.status_w = held_status;
              r.health_w = held_health;
              r.vel_w    = held_vel;
              r.left     = held_left[31:0];
              r.right    = held_right[31:0];
              r.pos_v    = {held_right[32], held_left[32]};
              r.diag_w   = held_diag;
              r.flags    = held_flags;
            end
          end
        end
      end
    end
    snap_exp_q.push_back(r);
  endtask

  // diagnostics bytes 3..7, often close to the drive-allowed combination
  function automatic logic [39:0] diag_payload();
    logic [7:0] fl, st, act, age, err;
    case ($urandom_range(0, 2))
      0: return {$urandom, 8'($urandom)};
      1: begin
        fl = 8'h06;
        st = 8'd4;
        act = 8'd1;
        age = 8'($urandom_range(0, 9));
        err = 8'd0;
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 4))
            0: fl = fl ^ (8'h01 << $urandom_range(0, 7));
            1: st = 8'($urandom_range(0, 8));
            2: act = 8'($urandom_range(0, 4));
            3: age = 8'($urandom_range(9, 11));
            default: err = 8'($urandom_range(0, 5));
          endcase
        end
      end
      default: begin
        fl = 8'($urandom_range(0, 15));
        st = 8'($urandom_range(0, 8));
        act = 8'($urandom_range(0, 4));
        age = 8'($urandom_range(0, 12));
        err = 8'($urandom_range(0, 5));
      end
    endcase
    return {err, age, act, st, fl};
  endfunction

  function automatic can_frame_t feedback_frame(input logic [2:0] slot, input logic [15:0] seq);
    can_frame_t f;
    logic [7:0] f3;
    f.cmd = 1'b0;
    f.ext = 1'b0;
    f.rem = 1'b0;
    f.len = csa_pkg::FRAME_LEN;
    f.id = (slot == csa_pkg::SLOT_DIAG) ? 29'(diag_id) : 29'(base_id) + 29'(slot);
    f.data = {$urandom, $urandom};
    f3 = 8'($urandom);
    case (slot)
      csa_pkg::SLOT_HEALTH:                    f3[4] = 1'b0;
      csa_pkg::SLOT_VEL:                       f3[7:2] = '0;
      csa_pkg::SLOT_LEFT, csa_pkg::SLOT_RIGHT: f3[7:1] = '0;
      default: ;
    endcase
    if (slot == csa_pkg::SLOT_DIAG) f.data[63:24] = diag_payload();
    else f.data[31:24] = f3;
    f.data[23:0] = {seq, proto_ver};
    return f;
  endfunction

  function automatic can_frame_t noise_frame();
    can_frame_t f;
    logic [2:0] sl;
    sl = 3'($urandom_range(1, 4));
    f = feedback_frame(3'($urandom_range(0, 5)), gen_seq);
    case ($urandom_range(0, 9))
      0: f.cmd = 1'b1;
      1: begin
        f.cmd = 1'($urandom);
        f.id = 29'($urandom);
        f.ext = 1'($urandom);
        f.rem = 1'($urandom);
        f.len = 4'($urandom);
        f.data = {$urandom, $urandom};
      end
      2: begin
        f.ext = 1'($urandom);
        f.rem = !f.ext || 1'($urandom);
      end
      3: begin
        f.id = $urandom_range(0, 1) ? 29'(opt_a) : 29'(opt_b);
        if ($urandom_range(0, 3) == 0) f.len = 4'($urandom);
        if ($urandom_range(0, 3) == 0) f.data[7:0] = 8'($urandom);
      end
      4: begin
        f.len = 4'($urandom_range(0, 14));
        if (f.len == csa_pkg::FRAME_LEN) f.len = 4'd15;
      end
      5: f.data[7:0] = proto_ver + 8'($urandom_range(1, 255));
      6: begin
        f = feedback_frame(sl, gen_seq);
        case (sl)
          csa_pkg::SLOT_HEALTH: f.data[28] = 1'b1;
          csa_pkg::SLOT_VEL:    f.data[24 + $urandom_range(2, 7)] = 1'b1;
          default:              f.data[24 + $urandom_range(1, 7)] = 1'b1;
        endcase
      end
      7: f = feedback_frame(3'($urandom_range(0, 5)), gen_seq - 16'($urandom_range(1, 32768)));
      8: f.id = 29'($urandom_range(0, 2047));
      default: f.id = 29'(base_id) + 29'($urandom_range(0, 8)) - 29'd2;
    endcase
    return f;
  endfunction

  // one sequence worth of feedback frames, shuffled, with drops, repeats and noise
  task automatic queue_group();
    logic [2:0] order[6];
    logic [2:0] t;
    int unsigned j, r;
    r = $urandom_range(0, 99);
    if (r < 55) gen_seq += 16'd1;
    else if (r >= 70 && r < 88) gen_seq += 16'($urandom_range(2, 32767));
    else if (r >= 88) gen_seq += csa_pkg::SEQ_WINDOW;
    for (int k = 0; k < 6; k++) order[k] = 3'(k);
    for (int k = 5; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < 6; k++) begin
      if ($urandom_range(0, 99) < 5) continue;
      frame_q.push_back(feedback_frame(order[k], gen_seq));
      if ($urandom_range(0, 99) < 8) frame_q.push_back(feedback_frame(order[k], gen_seq));
      if ($urandom_range(0, 99) < 8) frame_q.push_back(noise_frame());
    end
  endtask

  task automatic queue_directed();
    can_frame_t f;
    f = feedback_frame(csa_pkg::SLOT_STATUS, 16'hFFFF);
    f.cmd = 1'b1;
    frame_q.push_back(f);
    f = feedback_frame(csa_pkg::SLOT_STATUS, 16'd0);
    f.ext = 1'b1;
    f.id = '1;
    frame_q.push_back(f);
    f = feedback_frame(csa_pkg::SLOT_HEALTH, 16'd0);
    f.rem = 1'b1;
    frame_q.push_back(f);
    f.ext = 1'b1;
    frame_q.push_back(f);
    f = feedback_frame(csa_pkg::SLOT_STATUS, 16'd0);
    f.id = '0;
    frame_q.push_back(f);
    f.id = '1;                        // standard frame, id beyond 11 bits
    frame_q.push_back(f);
    f = feedback_frame(csa_pkg::SLOT_STATUS, 16'd0);
    f.id = 29'(opt_a);
    frame_q.push_back(f);
    f.id = 29'(opt_b);
    f.len = 4'd0;
    frame_q.push_back(f);
    f.len = csa_pkg::FRAME_LEN;
    f.data[7:0] = 8'hFF;
    frame_q.push_back(f);
    f = feedback_frame(csa_pkg::SLOT_VEL, 16'd1);
    f.len = 4'd7;
    frame_q.push_back(f);
    f = feedback_frame(csa_pkg::SLOT_DIAG, 16'd1);
    f.data[7:0] = 8'h00;
    frame_q.push_back(f);
    f = feedback_frame(csa_pkg::SLOT_HEALTH, 16'd1);
    f.data[28] = 1'b1;
    frame_q.push_back(f);
    f = feedback_frame(csa_pkg::SLOT_VEL, 16'd1);
    f.data[31:24] = 8'hFC;
    frame_q.push_back(f);
    f = feedback_frame(csa_pkg::SLOT_LEFT, 16'd1);
    f.data[31:24] = 8'hFE;
    frame_q.push_back(f);
    f = feedback_frame(csa_pkg::SLOT_RIGHT, 16'd1);
    f.data[31:24] = 8'h02;
    frame_q.push_back(f);
    // complete snapshot at the top sequence, extreme payloads, one repeated slot
    for (int k = 0; k < 6; k++) begin
      f = feedback_frame(3'(k), 16'hFFFF);
      f.data[63:32] = k[0] ? '1 : 32'h8000_0000;
      if (3'(k) == csa_pkg::SLOT_VEL) f.data[25:24] = 2'b11;
      if (3'(k) == csa_pkg::SLOT_LEFT || 3'(k) == csa_pkg::SLOT_RIGHT) f.data[24] = 1'b1;
      if (3'(k) == csa_pkg::SLOT_DIAG) f.data[63:24] = {8'd0, 8'd3, 8'd1, 8'd4, 8'h06};
      frame_q.push_back(f);
      if (3'(k) == csa_pkg::SLOT_VEL)
        frame_q.push_back(feedback_frame(csa_pkg::SLOT_VEL, 16'hFFFF));
    end
    frame_q.push_back(feedback_frame(csa_pkg::SLOT_STATUS, 16'h0000));   // wraps, newer
    frame_q.push_back(feedback_frame(csa_pkg::SLOT_HEALTH, 16'hFFFF));   // older
    frame_q.push_back(feedback_frame(csa_pkg::SLOT_HEALTH, 16'h8000));   // half range ahead
    f = feedback_frame(csa_pkg::SLOT_LEFT, 16'h0000);
    f.cmd = 1'b1;
    frame_q.push_back(f);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (frame_q.size() != 0 || s_axis_tvalid || snap_exp_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] ver, input logic [10:0] base, diag, a, b);
    logic [2:0]  idx[5];
    logic [10:0] vals[5];
    idx = '{csa_pkg::CFG_PROTOCOL_VERSION, csa_pkg::CFG_BASE_FEEDBACK_ID,
            csa_pkg::CFG_DIAGNOSTICS_ID, csa_pkg::CFG_OPTIONAL_ID_A, csa_pkg::CFG_OPTIONAL_ID_B};
    vals = '{{3'($urandom), ver}, base, diag, a, b};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index_i <= idx[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i);
      while (!cfg_ready_o);
      case (idx[i])
        csa_pkg::CFG_PROTOCOL_VERSION: proto_ver = vals[i][7:0];
        csa_pkg::CFG_BASE_FEEDBACK_ID: base_id = vals[i];
        csa_pkg::CFG_DIAGNOSTICS_ID:   diag_id = vals[i];
        csa_pkg::CFG_OPTIONAL_ID_A:    opt_a = vals[i];
        default:                       opt_b = vals[i];
      endcase
    end
    cfg_valid_i <= 1'b0;
    while (frame_q.size() < 285) begin
      if ($urandom_range(0, 99) < 65) queue_group();
      else frame_q.push_back(noise_frame());
    end
    wait_drained();
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fault_cnt++;
    if (fault_cnt <= MaxPrinted)
      $display("mismatch word %0d %s: got %h want %h", words_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // frame driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) assemble_snapshot(cur_frame);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (frame_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_frame = frame_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_frame.cmd;
          s_axis_tdata <= {5'b0, cur_frame.data, cur_frame.len, cur_frame.rem, cur_frame.ext,
                           cur_frame.id};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_seen++;
        if (snap_exp_q.size() == 0) begin
          report_mismatch("unexpected word, tuser", 64'(m_axis_tuser), 64'd0);
        end else begin
          want_snap = snap_exp_q.pop_front();
          check_field("decode_status", 64'(m_axis_tuser[2:0]), 64'(want_snap.status));
          check_field("snapshot_valid", 64'(m_axis_tuser[3]), 64'(want_snap.valid));
          check_field("snapshot_sequence", 64'(m_axis_tdata[15:0]), 64'(want_snap.seq));
          check_field("status_word", 64'(m_axis_tdata[55:16]), 64'(want_snap.status_w));
          check_field("health_word", 64'(m_axis_tdata[95:56]), 64'(want_snap.health_w));
          check_field("velocity_word", 64'(m_axis_tdata[129:96]), 64'(want_snap.vel_w));
          check_field("left_position", 64'(m_axis_tdata[161:130]), 64'(want_snap.left));
          check_field("right_position", 64'(m_axis_tdata[193:162]), 64'(want_snap.right));
          check_field("position_valid", 64'(m_axis_tdata[195:194]), 64'(want_snap.pos_v));
          check_field("diagnostics_word", 64'(m_axis_tdata[235:196]), 64'(want_snap.diag_w));
          check_field("drive_flags", 64'(m_axis_tdata[239:236]), 64'(want_snap.flags));
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    queue_directed();
    wait_drained();
    run_phase(8'h00, 11'd0, 11'd2047, 11'd5, 11'd2046);
    idle_pct = 0;
    stall_pct = 0;
    // diagnostics id inside the main range
    run_phase(8'hFF, 11'd2043, 11'd2045, 11'd0, 11'd2047);
    idle_pct = 24;
    stall_pct = 24;
    // base near the top, upper slots only reachable with ids past 2047
    run_phase(8'h5A, 11'd2046, 11'd100, 11'd2046, 11'd101);
    run_phase(8'h80, 11'd640, 11'd645, 11'd646, 11'd639);
    run_phase(8'($urandom), 11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
    run_phase(8'h01, 11'd256, 11'd261, 11'd262, 11'd263);
    if (fault_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
